// ===== sv/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg: shared definitions for the support polygon clamp
// Holds the default widths, the projection fraction and the sequencer states.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int T_BITS          = 16;
    localparam int N_FEET          = 4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_T,
        S_DIV,
        S_M6,
        S_M7,
        S_M8,
        S_M9,
        S_CMP,
        S_OUT
    } t_state;

endpackage

// ===== sv/spc_in_if.sv =====
// ----------------------------------------------------------------------------
// spc_in_if: input channel of the support polygon clamp
// Four foot points, the contact mask and the reference point.
// ----------------------------------------------------------------------------
interface spc_in_if #(
    parameter int CW = spc_pkg::COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] foot0_x;
    logic signed [CW-1:0] foot0_z;
    logic signed [CW-1:0] foot1_x;
    logic signed [CW-1:0] foot1_z;
    logic signed [CW-1:0] foot2_x;
    logic signed [CW-1:0] foot2_z;
    logic signed [CW-1:0] foot3_x;
    logic signed [CW-1:0] foot3_z;
    logic [3:0]           contact_mask;
    logic signed [CW-1:0] ref_x;
    logic signed [CW-1:0] ref_z;

    modport source (output valid, foot0_x, foot0_z, foot1_x, foot1_z, foot2_x, foot2_z,
                    foot3_x, foot3_z, contact_mask, ref_x, ref_z, input ready);
    modport sink   (input valid, foot0_x, foot0_z, foot1_x, foot1_z, foot2_x, foot2_z,
                    foot3_x, foot3_z, contact_mask, ref_x, ref_z, output ready);
endinterface

// ===== sv/spc_out_if.sv =====
// ----------------------------------------------------------------------------
// spc_out_if: result channel of the support polygon clamp
// Valid flag and the clamped support point.
// ----------------------------------------------------------------------------
interface spc_out_if #(
    parameter int CW = spc_pkg::COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_z;

    modport source (output valid, ok, out_x, out_z, input ready);
    modport sink   (input valid, ok, out_x, out_z, output ready);
endinterface

// ===== sv/support_polygon_clamp_unit.sv =====
// ----------------------------------------------------------------------------
// support_polygon_clamp_unit: clamp a reference point to the support polygon
// Gathers the feet in contact (order 0,1,3,2) and finds the nearest point on
// the closed edge chain with one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : valid/ready transfer of four foot points, a contact mask and the
//           reference point. Taken only while the sequencer is idle.
//   o_out : valid/ready transfer of ok and the clamped point.
// Sequence:
//   no foot or one foot in contact: straight to the output state.
//   n >= 2 feet: per edge load, six products, projection step, four
//   products and compare, with a divider run (start and 16 quotient bits)
//   after the projection step when the projection falls strictly inside
//   the edge, then the output state. The shared multiplier sets the
//   per-edge steps: six products for side, length and dot, two for the
//   candidate point and two for the distance.
// Overlap: one item at a time; the next item is taken while a result
//   still waits in the output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// Stall: a held result keeps its register; the sequencer waits in its
//   output state until the register is free, then returns to idle.
// ----------------------------------------------------------------------------
module support_polygon_clamp_unit #(
    parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = spc_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spc_in_if.sink    i_in,
    spc_out_if.source o_out
);
    localparam int W      = COORD_WIDTH;
    localparam int TB     = spc_pkg::T_BITS;
    // operands: coordinate differences (W+1) or the signed t (TB+2)
    localparam int MW     = (W + 1 > TB + 2) ? W + 1 : TB + 2;
    localparam int PW     = 2 * MW + 1;
    localparam longint Thresh = ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;
    localparam logic signed [PW-1:0] ThrW  = PW'(Thresh);
    localparam logic signed [PW-1:0] NThrW = -PW'(Thresh);
    localparam logic signed [PW-1:0] HalfW = PW'(64'd1 << (TB - 1));
    localparam logic [TB:0]          TOne  = (TB+1)'(1) << TB;

    spc_pkg::t_state r_state, n_state;

    // gathered polygon, rotated so that slot 0 is the edge start
    logic signed [W-1:0] r_px [spc_pkg::N_FEET];
    logic signed [W-1:0] r_pz [spc_pkg::N_FEET];
    logic [2:0]          r_cnt;
    logic [1:0]          r_j;
    logic signed [W-1:0] r_rx, r_rz;

    logic signed [W:0]    r_ex, r_ez, r_qx, r_qz;
    logic signed [PW-1:0] r_acc, r_side, r_len2, r_best;
    logic [TB:0]          r_t;
    logic signed [W-1:0]  r_cx, r_cz;
    logic                 r_have, r_pos, r_neg;

    // working result, copied to the output register when it is free
    logic                 r_bok;
    logic signed [W-1:0]  r_bx, r_bz;

    logic                 r_ovalid, r_ok;
    logic signed [W-1:0]  r_ox, r_oz;

    // input compaction
    logic signed [W-1:0] g_x [spc_pkg::N_FEET];
    logic signed [W-1:0] g_z [spc_pkg::N_FEET];
    logic [2:0]          g_cnt;
    logic signed [W-1:0] f_x [spc_pkg::N_FEET];
    logic signed [W-1:0] f_z [spc_pkg::N_FEET];
    logic [1:0]          ord [spc_pkg::N_FEET];

    logic                     accept;
    logic                     out_free;
    logic signed [MW-1:0]     mul_a, mul_b;
    logic signed [2*MW-1:0]   prod;
    logic signed [PW-1:0]     prod_w, dot_now, dist_now, rnd;
    logic signed [W:0]        dx, dz;
    logic                     div_start, div_done;
    logic [TB-1:0]            div_q;
    logic                     last_edge;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == spc_pkg::S_IDLE);

    assign f_x[0] = i_in.foot0_x; assign f_z[0] = i_in.foot0_z;
    assign f_x[1] = i_in.foot1_x; assign f_z[1] = i_in.foot1_z;
    assign f_x[2] = i_in.foot2_x; assign f_z[2] = i_in.foot2_z;
    assign f_x[3] = i_in.foot3_x; assign f_z[3] = i_in.foot3_z;
    assign ord[0] = 2'd0; assign ord[1] = 2'd1; assign ord[2] = 2'd3; assign ord[3] = 2'd2;

    // pack feet in contact into consecutive slots, polygon order
    always_comb begin
        g_cnt = '0;
        for (int k = 0; k < spc_pkg::N_FEET; k++) begin
            g_x[k] = '0;
            g_z[k] = '0;
        end
        for (int k = 0; k < spc_pkg::N_FEET; k++) begin
            if (i_in.contact_mask[ord[k]]) begin
                g_x[g_cnt[1:0]] = f_x[ord[k]];
                g_z[g_cnt[1:0]] = f_z[ord[k]];
                g_cnt = g_cnt + 3'd1;
            end
        end
    end

    assign prod_w   = PW'(prod);
    assign dot_now  = r_acc + prod_w;
    assign dist_now = r_acc + prod_w;
    // round half toward +inf, then offset from the edge start
    assign rnd      = (prod_w + HalfW) >>> TB;
    assign dx       = (W+1)'(r_rx) - (W+1)'(r_cx);
    assign dz       = (W+1)'(r_rz) - (W+1)'(r_cz);
    assign last_edge = ({1'b0, r_j} == r_cnt - 3'd1);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            spc_pkg::S_M0: begin mul_a = MW'(r_ex); mul_b = MW'(r_qz); end
            spc_pkg::S_M1: begin mul_a = MW'(r_ez); mul_b = MW'(r_qx); end
            spc_pkg::S_M2: begin mul_a = MW'(r_ex); mul_b = MW'(r_ex); end
            spc_pkg::S_M3: begin mul_a = MW'(r_ez); mul_b = MW'(r_ez); end
            spc_pkg::S_M4: begin mul_a = MW'(r_qx); mul_b = MW'(r_ex); end
            spc_pkg::S_M5: begin mul_a = MW'(r_qz); mul_b = MW'(r_ez); end
            spc_pkg::S_M6: begin mul_a = MW'(r_ex); mul_b = MW'($signed({1'b0, r_t})); end
            spc_pkg::S_M7: begin mul_a = MW'(r_ez); mul_b = MW'($signed({1'b0, r_t})); end
            spc_pkg::S_M8: begin mul_a = MW'(dx);   mul_b = MW'(dx); end
            spc_pkg::S_M9: begin mul_a = MW'(dz);   mul_b = MW'(dz); end
            default: ;
        endcase
    end

    spc_mul #(.MW(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // divide only when the edge is not degenerate and 0 < dot < len2
    assign div_start = (r_state == spc_pkg::S_T) && (r_len2 > ThrW)
                       && (dot_now > 0) && (dot_now < r_len2);

    spc_div #(.PW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (dot_now),
        .i_den   (r_len2),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            spc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (g_cnt < 3'd2) ? spc_pkg::S_OUT : spc_pkg::S_LOAD;
                end
            end
            spc_pkg::S_LOAD: n_state = spc_pkg::S_M0;
            spc_pkg::S_M0:   n_state = spc_pkg::S_M1;
            spc_pkg::S_M1:   n_state = spc_pkg::S_M2;
            spc_pkg::S_M2:   n_state = spc_pkg::S_M3;
            spc_pkg::S_M3:   n_state = spc_pkg::S_M4;
            spc_pkg::S_M4:   n_state = spc_pkg::S_M5;
            spc_pkg::S_M5:   n_state = spc_pkg::S_T;
            spc_pkg::S_T:    n_state = div_start ? spc_pkg::S_DIV : spc_pkg::S_M6;
            spc_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = spc_pkg::S_M6;
                end
            end
            spc_pkg::S_M6:   n_state = spc_pkg::S_M7;
            spc_pkg::S_M7:   n_state = spc_pkg::S_M8;
            spc_pkg::S_M8:   n_state = spc_pkg::S_M9;
            spc_pkg::S_M9:   n_state = spc_pkg::S_CMP;
            spc_pkg::S_CMP:  n_state = last_edge ? spc_pkg::S_OUT : spc_pkg::S_LOAD;
            spc_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = spc_pkg::S_IDLE;
                end
            end
            default: n_state = spc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spc_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == spc_pkg::S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            spc_pkg::S_IDLE: begin
                if (accept) begin
                    for (int k = 0; k < spc_pkg::N_FEET; k++) begin
                        r_px[k] <= g_x[k];
                        r_pz[k] <= g_z[k];
                    end
                    r_cnt  <= g_cnt;
                    r_j    <= '0;
                    r_rx   <= i_in.ref_x;
                    r_rz   <= i_in.ref_z;
                    r_have <= 1'b0;
                    r_pos  <= 1'b0;
                    r_neg  <= 1'b0;
                    r_best <= '0;
                    // hold the foot itself, or zero when no contact
                    r_bok  <= (g_cnt != 3'd0);
                    r_bx   <= g_x[0];
                    r_bz   <= g_z[0];
                end
            end
            spc_pkg::S_LOAD: begin
                r_ex <= (W+1)'(r_px[1]) - (W+1)'(r_px[0]);
                r_ez <= (W+1)'(r_pz[1]) - (W+1)'(r_pz[0]);
                r_qx <= (W+1)'(r_rx) - (W+1)'(r_px[0]);
                r_qz <= (W+1)'(r_rz) - (W+1)'(r_pz[0]);
            end
            spc_pkg::S_M1: r_acc  <= prod_w;
            spc_pkg::S_M2: r_side <= r_acc - prod_w;
            spc_pkg::S_M3: begin
                r_acc <= prod_w;
                if (r_side > ThrW)  r_pos <= 1'b1;
                if (r_side < NThrW) r_neg <= 1'b1;
            end
            spc_pkg::S_M4: r_len2 <= r_acc + prod_w;
            spc_pkg::S_M5: r_acc  <= prod_w;
            spc_pkg::S_T: begin
                if (r_len2 <= ThrW || dot_now <= 0) begin
                    r_t <= '0;
                end else if (dot_now >= r_len2) begin
                    r_t <= TOne;
                end
            end
            spc_pkg::S_DIV: begin
                if (div_done) r_t <= {1'b0, div_q};
            end
            spc_pkg::S_M7: r_cx <= r_px[0] + W'(rnd);
            spc_pkg::S_M8: r_cz <= r_pz[0] + W'(rnd);
            spc_pkg::S_M9: r_acc <= prod_w;
            spc_pkg::S_CMP: begin
                // keep the first strict minimum
                if (!r_have || dist_now < r_best) begin
                    r_have <= 1'b1;
                    r_best <= dist_now;
                end
                if (last_edge && r_cnt > 3'd2 && !(r_pos && r_neg)) begin
                    // reference inside the polygon: pass it through
                    r_bx <= r_rx;
                    r_bz <= r_rz;
                end else if (!r_have || dist_now < r_best) begin
                    r_bx <= r_cx;
                    r_bz <= r_cz;
                end
                if (!last_edge) begin
                    // advance: rotate the active slots by one
                    for (int k = 0; k < spc_pkg::N_FEET - 1; k++) begin
                        r_px[k] <= (3'(k + 1) == r_cnt) ? r_px[0] : r_px[k+1];
                        r_pz[k] <= (3'(k + 1) == r_cnt) ? r_pz[0] : r_pz[k+1];
                    end
                    if (r_cnt == 3'(spc_pkg::N_FEET)) begin
                        r_px[spc_pkg::N_FEET-1] <= r_px[0];
                        r_pz[spc_pkg::N_FEET-1] <= r_pz[0];
                    end
                    r_j <= r_j + 2'd1;
                end
            end
            spc_pkg::S_OUT: begin
                if (out_free) begin
                    r_ok <= r_bok;
                    r_ox <= r_bx;
                    r_oz <= r_bz;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid = r_ovalid;
    assign o_out.ok    = r_ok;
    assign o_out.out_x = r_ox;
    assign o_out.out_z = r_oz;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_div_only_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spc_pkg::S_DIV |-> r_cnt >= 3'd2)
        else $error("divider busy without an edge");

    a_edge_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spc_pkg::S_CMP |-> {1'b0, r_j} < r_cnt)
        else $error("edge index past polygon size");

    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ok) |-> (o_out.out_x == '0 && o_out.out_z == '0))
        else $error("invalid result with nonzero point");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == spc_pkg::S_M6 |-> r_t <= TOne)
        else $error("projection parameter above one");
endmodule

// ===== sv/spc_mul.sv =====
// ----------------------------------------------------------------------------
// spc_mul: shared signed multiplier
// One product per cycle, registered output.
// ----------------------------------------------------------------------------
module spc_mul #(
    parameter int MW = 25
) (
    input  logic                   i_clk,
    input  logic signed [MW-1:0]   i_a,
    input  logic signed [MW-1:0]   i_b,
    output logic signed [2*MW-1:0] o_p
);
    logic signed [2*MW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (2*MW)'(i_a) * (2*MW)'(i_b);
    end

    assign o_p = r_p;
endmodule

// ===== sv/spc_div.sv =====
// ----------------------------------------------------------------------------
// spc_div: restoring divider for the projection parameter
// Gives floor(num * 2^T_BITS / den) for 0 < num < den, one bit a cycle.
// ----------------------------------------------------------------------------
module spc_div #(
    parameter int PW = 51
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [PW-1:0]      i_num,
    input  logic signed [PW-1:0]      i_den,
    output logic                      o_done,
    output logic [spc_pkg::T_BITS-1:0] o_q
);
    localparam int CntW = $clog2(spc_pkg::T_BITS + 1);

    logic [PW:0]                   r_rem;
    logic [PW:0]                   r_den;
    logic [spc_pkg::T_BITS-1:0]    r_q;
    logic [CntW-1:0]               r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [PW:0]                   rem2;
    logic                          ge;

    assign rem2 = {r_rem[PW-1:0], 1'b0};
    assign ge   = rem2 >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(spc_pkg::T_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (PW+1)'(unsigned'(i_num));
            r_den <= (PW+1)'(unsigned'(i_den));
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem2 - r_den : rem2;
            r_q   <= {r_q[spc_pkg::T_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

// ===== bench/support_polygon_clamp_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// support_polygon_clamp_unit_test: self-checking bench for the polygon clamp
// Drives foot sets, contact masks and reference points through the input
// channel, predicts each clamped point with an exact integer model and
// compares every result transfer in order, under several idling phases.
// ----------------------------------------------------------------------------
module support_polygon_clamp_unit_test;

    localparam int CW = spc_pkg::COORD_WIDTH_DEF;
    localparam int FB = spc_pkg::FRAC_BITS_DEF;
    localparam int TBITS = spc_pkg::T_BITS;
    localparam longint THRESH = ((64'd1 << (2 * FB)) + 5000) / 10000;
    localparam longint T_ONE = 64'd1 << TBITS;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_OFF_CYCLES = 600;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic   ok;
        t_coord px;
        t_coord pz;
    } t_clamp;

    logic i_clk;
    logic i_rst_n;

    spc_in_if  #(.CW(CW)) in_ch ();
    spc_out_if #(.CW(CW)) out_ch ();

    support_polygon_clamp_unit #(
        .COORD_WIDTH(CW),
        .FRAC_BITS  (FB)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_clamp expected_points[$];
    int     mismatches = 0;
    int     src_idle_pct;
    int     snk_stall_pct;
    int     hold_off_req;
    int     hold_off_taken = 0;
    int     hold_left = 0;
    longint cycle_count = 0;
    bit     timed_out = 1'b0;

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Clamp a reference point to the contact polygon; the 128-bit signed
    // products and the 64-bit candidate offsets are exact.
    function automatic t_clamp clamp_point(input t_coord f[8], input logic [3:0] mask,
                                           input t_coord rx, input t_coord rz);
        int              order[4];
        longint          hx[4];
        longint          hz[4];
        int              n;
        int              nx;
        longint          ax, az, ex, ez, qx, qz, t, cx, cz, dx, dz, bx, bz, p, q;
        logic signed [127:0] side, len2, dotp, dsq, best, rem;
        bit              have, pos, neg;
        t_clamp          res;
        order = '{0, 1, 3, 2};
        n = 0;
        have = 0;
        pos = 0;
        neg = 0;
        bx = 0;
        bz = 0;
        best = 0;
        for (int j = 0; j < 4; j++) begin
            if (mask[order[j]]) begin
                hx[n] = f[2 * order[j]];
                hz[n] = f[2 * order[j] + 1];
                n++;
            end
        end
        res = '0;
        if (n == 0) begin
            return res;
        end
        if (n == 1) begin
            bx = hx[0];
            bz = hz[0];
        end else begin
            for (int j = 0; j < n; j++) begin
                nx = (j + 1) % n;
                ax = hx[j];
                az = hz[j];
                ex = hx[nx] - ax;
                ez = hz[nx] - az;
                qx = rx - ax;
                qz = rz - az;
                side = 128'(ex) * 128'(qz) - 128'(ez) * 128'(qx);
                len2 = 128'(ex) * 128'(ex) + 128'(ez) * 128'(ez);
                dotp = 128'(qx) * 128'(ex) + 128'(qz) * 128'(ez);
                if (side > THRESH) pos = 1;
                if (side < -THRESH) neg = 1;
                t = 0;
                if (len2 > THRESH) begin
                    if (dotp <= 0) begin
                        t = 0;
                    end else if (dotp >= len2) begin
                        t = T_ONE;
                    end else begin
                        rem = dotp <<< TBITS;
                        t = longint'(rem / len2);
                    end
                end
                // round half toward +infinity, shift floors
                p = (ex * t + (T_ONE >>> 1)) >>> TBITS;
                q = (ez * t + (T_ONE >>> 1)) >>> TBITS;
                cx = ax + p;
                cz = az + q;
                dx = rx - cx;
                dz = rz - cz;
                dsq = 128'(dx) * 128'(dx) + 128'(dz) * 128'(dz);
                if (!have || dsq < best) begin
                    have = 1;
                    best = dsq;
                    bx = cx;
                    bz = cz;
                end
            end
            if (n > 2 && !(pos && neg)) begin
                bx = rx;
                bz = rz;
            end
        end
        res.ok = 1'b1;
        res.px = t_coord'(bx);
        res.pz = t_coord'(bz);
        return res;
    endfunction

    // Send one item; hold valid across back-to-back transfers.
    task automatic send_item(input t_coord f[8], input logic [3:0] mask,
                             input t_coord rx, input t_coord rz);
        int idle;
        idle = 0;
        while ($urandom_range(99, 0) < src_idle_pct && idle < 20) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
            idle++;
        end
        in_ch.valid        <= 1'b1;
        in_ch.foot0_x      <= f[0];
        in_ch.foot0_z      <= f[1];
        in_ch.foot1_x      <= f[2];
        in_ch.foot1_z      <= f[3];
        in_ch.foot2_x      <= f[4];
        in_ch.foot2_z      <= f[5];
        in_ch.foot3_x      <= f[6];
        in_ch.foot3_z      <= f[7];
        in_ch.contact_mask <= mask;
        in_ch.ref_x        <= rx;
        in_ch.ref_z        <= rz;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_points.push_back(clamp_point(f, mask, rx, rz));
        @(negedge i_clk);
    endtask

    function automatic t_coord rand_coord(input int span);
        case ($urandom_range(9, 0))
            0: return t_coord'({1'b0, {(CW-1){1'b1}}});
            1: return t_coord'({1'b1, {(CW-1){1'b0}}});
            2, 3: return t_coord'($urandom);
            default: return t_coord'(int'($urandom_range(2 * span, 0)) - span);
        endcase
    endfunction

    task automatic send_random(input int count, input int span);
        t_coord f[8];
        t_coord rx, rz;
        for (int i = 0; i < count; i++) begin
            foreach (f[k]) f[k] = rand_coord(span);
            // a coincident pair now and then exercises degenerate edges
            if ($urandom_range(15, 0) == 0) begin
                f[2] = f[0];
                f[3] = f[1] + t_coord'($urandom_range(2, 0));
            end
            rx = rand_coord(span * 2);
            rz = rand_coord(span * 2);
            send_item(f, 4'($urandom), rx, rz);
        end
    endtask

    // Drop valid, then wait until every expected result is back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Directed corners: every mask, the field extremes, a square with the
    // reference inside and outside, a two-foot segment, a zero-length edge.
    task automatic test_directed();
        t_coord sq[8];
        t_coord mx, mn;
        mx = t_coord'({1'b0, {(CW-1){1'b1}}});
        mn = t_coord'({1'b1, {(CW-1){1'b0}}});
        sq = '{-1000, -1000, 1000, -1000, -1000, 1000, 1000, 1000};
        for (int m = 0; m < 16; m++) send_item(sq, 4'(m), 3000, 200);
        send_item(sq, 4'hF, 10, -20);
        send_item(sq, 4'b0011, 0, 500);
        send_item('{mx, mx, mn, mn, mx, mn, mn, mx}, 4'hF, mn, mx);
        send_item('{mn, mn, mx, mx, mn, mx, mx, mn}, 4'hF, mx, mn);
        send_item('{mx, mn, mx, mn, 0, 0, 0, 0}, 4'b0011, 0, 0);
        send_item('{5, 5, 5, 5, 5, 5, 90, -4}, 4'b1011, 7, -300);
        send_item('{-1, -1, 0, 0, 1, 1, -1, 0}, 4'hF, mx, mn);
        wait_drained();
    endtask

    task automatic test_no_idle();
        src_idle_pct = 0; snk_stall_pct = 0;
        send_random(300, 4000);
        wait_drained();
    endtask

    task automatic test_sender_idle();
        src_idle_pct = 58; snk_stall_pct = 0;
        send_random(250, 1 << 20);
        wait_drained();
    endtask

    task automatic test_receiver_stall();
        src_idle_pct = 0; snk_stall_pct = 58;
        send_random(250, 300);
        wait_drained();
    endtask

    task automatic test_both_idle();
        src_idle_pct = 10; snk_stall_pct = 10;
        send_random(250, 1 << 16);
        wait_drained();
    endtask

    // Hold the receiver off long enough for the block to fill and stall its
    // input, then let the sender pause until all results are back.
    task automatic test_back_pressure();
        src_idle_pct = 0; snk_stall_pct = 0;
        hold_off_req++;
        send_random(200, 2000);
        wait_drained();
        send_random(50, 1 << 22);
        wait_drained();
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off_taken != hold_off_req) begin
            hold_off_taken <= hold_off_req;
            hold_left <= HOLD_OFF_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_clamp want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ok=%0b x=%0d z=%0d",
                             out_ch.ok, out_ch.out_x, out_ch.out_z);
            end else begin
                want = expected_points.pop_front();
                if (out_ch.ok !== want.ok || out_ch.out_x !== want.px
                        || out_ch.out_z !== want.pz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ok=%0b x=%0d z=%0d, got ok=%0b x=%0d z=%0d",
                                 want.ok, want.px, want.pz,
                                 out_ch.ok, out_ch.out_x, out_ch.out_z);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES && !timed_out) begin
            timed_out <= 1'b1;
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        hold_off_req = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.foot0_x = '0; in_ch.foot0_z = '0;
        in_ch.foot1_x = '0; in_ch.foot1_z = '0;
        in_ch.foot2_x = '0; in_ch.foot2_z = '0;
        in_ch.foot3_x = '0; in_ch.foot3_z = '0;
        in_ch.contact_mask = '0;
        in_ch.ref_x = '0; in_ch.ref_z = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_back_pressure();
        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
